// ----- hdl/twd_pkg.sv -----
// Package for the task watchdog supervisor.
// Holds slot constants, operation and status codes, and the types shared by
// the slot cells and the top level. Depends on nothing.
`default_nettype none

package twd_pkg;

    localparam int SLOTS = 64;
    localparam int ID_W = 8;
    localparam int KEY_W = 64;
    localparam int CNT_W = 32;
    localparam logic [CNT_W-1:0] TIMEOUT_RESET = CNT_W'(10);

    typedef enum logic [1:0] {
        KIND_REGISTER   = 2'd0,
        KIND_UNREGISTER = 2'd1,
        KIND_RELOAD     = 2'd2,
        KIND_TICK       = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_DUPLICATE = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_WALK = 1'b1
    } t_state;

    // Walk token handed from cell to cell, one cell per cycle.
    typedef struct packed {
        logic            valid;
        logic            tick;
        logic            dup;
        logic [ID_W-1:0] dup_id;
        logic            free;
        logic [ID_W-1:0] free_id;
        logic            stop;
        logic [ID_W-1:0] stop_id;
    } t_tok;

    // Direct slot write broadcast to all cells.
    typedef struct packed {
        logic             alloc;
        logic             unreg;
        logic             reload;
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] value;
    } t_wr;

endpackage

`default_nettype wire

// ----- hdl/task_watchdog_supervisor.sv -----
// Task watchdog supervisor top level: request control and the row of slot cells.
// Register and tick requests pass a token through the launch register and
// each cell of the walk chain before the result strobe; unregister and
// reload answer in the next cycle. No request is taken while a register or tick
// walk runs (busy high); unregister and reload allow one per cycle.
// Synchronous active-low reset frees all slots, clears counters and the fault.
// Depends on twd_pkg and twd_cell.
`default_nettype none

module task_watchdog_supervisor
    import twd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    output logic                  o_busy,
    input  wire logic [1:0]       i_kind,
    input  wire logic [KEY_W-1:0] i_task_key,
    input  wire logic [ID_W-1:0]  i_task_id,
    input  wire logic             i_cfg_we,
    input  wire logic [CNT_W-1:0] i_cfg_wdata,
    output logic                  o_valid,
    output logic                  o_ok,
    output logic [ID_W-1:0]       o_result_id,
    output logic [1:0]            o_status,
    output logic                  o_feed
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_state           r_state;
    t_state           n_state;
    t_tok             r_launch;
    t_tok             n_launch;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;
    logic             r_fault;
    logic             n_fault;
    logic [CNT_W-1:0] r_timeout;
    logic             r_valid;
    logic             n_valid;
    logic             r_ok;
    logic             n_ok;
    logic [ID_W-1:0]  r_rid;
    logic [ID_W-1:0]  n_rid;
    t_status          r_status;
    t_status          n_status;
    logic             r_feed;
    logic             n_feed;

    t_wr              wr;
    t_tok             tok [0:SLOTS];
    logic [SLOTS-1:0] used_vec;
    logic             accept;
    logic             id_hit;
    logic [ID_W-1:0]  id_m1;
    logic             tick_fault;
    t_kind            kind;

    assign kind   = t_kind'(i_kind);
    assign accept = i_start && (r_state == S_IDLE);
    assign id_m1  = i_task_id - ID_W'(1);
    assign id_hit = (i_task_id != '0) && (i_task_id <= ID_W'(SLOTS))
                    && used_vec[id_m1[IDX_W-1:0]];
    assign tick_fault = r_fault || tok[SLOTS].stop;

    assign tok[0] = r_launch;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        twd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_id    (ID_W'(g + 1)),
            .i_key   (r_key),
            .i_wr    (wr),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1]),
            .o_used  (used_vec[g])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && ((kind == KIND_REGISTER) || (kind == KIND_TICK))) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (tok[SLOTS].valid) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        n_launch = '0;
        n_key    = r_key;
        n_fault  = r_fault;
        n_valid  = 1'b0;
        n_ok     = r_ok;
        n_rid    = r_rid;
        n_status = r_status;
        n_feed   = r_feed;
        wr       = '0;
        wr.value = r_timeout;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (kind)
                        KIND_REGISTER, KIND_TICK: begin
                            n_launch.valid = 1'b1;
                            n_launch.tick  = (kind == KIND_TICK);
                            n_key          = i_task_key;
                        end
                        KIND_UNREGISTER, KIND_RELOAD: begin
                            n_valid = 1'b1;
                            n_rid   = '0;
                            n_feed  = 1'b0;
                            wr.id   = i_task_id;
                            if (id_hit) begin
                                n_ok      = 1'b1;
                                n_status  = STATUS_DONE;
                                wr.unreg  = (kind == KIND_UNREGISTER);
                                wr.reload = (kind == KIND_RELOAD);
                            end else begin
                                n_ok     = 1'b0;
                                n_status = STATUS_NOT_FOUND;
                            end
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (tok[SLOTS].valid) begin
                    n_valid = 1'b1;
                    if (tok[SLOTS].tick) begin
                        n_fault  = tick_fault;
                        n_ok     = !tick_fault;
                        n_feed   = !tick_fault;
                        n_status = STATUS_DONE;
                        n_rid    = tok[SLOTS].stop ? tok[SLOTS].stop_id : '0;
                    end else begin
                        n_feed = 1'b0;
                        priority if (tok[SLOTS].dup) begin
                            n_ok     = 1'b0;
                            n_status = STATUS_DUPLICATE;
                            n_rid    = tok[SLOTS].dup_id;
                        end else if (tok[SLOTS].free) begin
                            n_ok     = 1'b1;
                            n_status = STATUS_DONE;
                            n_rid    = tok[SLOTS].free_id;
                            wr.alloc = 1'b1;
                            wr.id    = tok[SLOTS].free_id;
                        end else begin
                            n_ok     = 1'b0;
                            n_status = STATUS_FULL;
                            n_rid    = '0;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_launch  <= '0;
            r_fault   <= 1'b0;
            r_timeout <= TIMEOUT_RESET;
            r_valid   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= n_launch;
            r_fault  <= n_fault;
            r_valid  <= n_valid;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_ok     <= n_ok;
        r_rid    <= n_rid;
        r_status <= n_status;
        r_feed   <= n_feed;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_ok        = r_ok;
    assign o_result_id = r_rid;
    assign o_status    = r_status;
    assign o_feed      = r_feed;

    a_tail_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok[SLOTS].valid |-> (r_state == S_WALK))
        else $error("walk token left the chain outside a walk");

    a_fault_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault |=> r_fault)
        else $error("latched fault was cleared");

    a_feed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_feed) |-> (o_ok && !r_fault))
        else $error("feed given while a fault is latched");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({wr.alloc, wr.unreg, wr.reload}))
        else $error("more than one slot write at once");

endmodule

`default_nettype wire

// ----- hdl/twd_cell.sv -----
// One supervisor slot: used bit, name key and tick counter.
// Processes the walk token passing through it and takes direct slot writes.
// Depends on twd_pkg.
`default_nettype none

module twd_cell
    import twd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [ID_W-1:0]  i_id,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire t_wr              i_wr,
    input  wire t_tok             i_tok,
    output t_tok                  o_tok,
    output logic                  o_used
);

    logic             r_used;
    logic             n_used;
    logic [CNT_W-1:0] r_counter;
    logic [CNT_W-1:0] n_counter;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;
    t_tok             r_tok;
    t_tok             n_tok;

    always_comb begin
        n_tok     = i_tok;
        n_used    = r_used;
        n_counter = r_counter;
        n_key     = r_key;
        if (i_tok.valid) begin
            if (i_tok.tick) begin
                if (r_used && !i_tok.stop) begin
                    if (r_counter == '0) begin
                        n_tok.stop    = 1'b1;
                        n_tok.stop_id = i_id;
                    end else begin
                        n_counter = r_counter - CNT_W'(1);
                    end
                end
            end else begin
                if (r_used && (r_key == i_key) && !i_tok.dup) begin
                    n_tok.dup    = 1'b1;
                    n_tok.dup_id = i_id;
                end
                if (!r_used && !i_tok.free) begin
                    n_tok.free    = 1'b1;
                    n_tok.free_id = i_id;
                end
            end
        end
        if (i_wr.id == i_id) begin
            if (i_wr.alloc) begin
                n_used = 1'b1;
                n_key  = i_key;
            end
            if (i_wr.unreg) begin
                n_used = 1'b0;
            end
            if (i_wr.reload) begin
                n_counter = i_wr.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= 1'b0;
            r_counter <= '0;
            r_tok     <= '0;
        end else begin
            r_used    <= n_used;
            r_counter <= n_counter;
            r_tok     <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_tok  = r_tok;
    assign o_used = r_used;

endmodule

`default_nettype wire

// ----- verif/task_watchdog_supervisor_tb.sv -----
// Self-checking testbench for the task watchdog supervisor.
// Drives directed and random requests, predicts each reply and compares it.
// Depends on twd_pkg and the task_watchdog_supervisor RTL.
module task_watchdog_supervisor_tb
    import twd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic            ok;
        logic [ID_W-1:0] rid;
        t_status         status;
        logic            feed;
    } t_reply;

    typedef struct packed {
        t_kind            kind;
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
        logic             typed;
        t_reply           want;
    } t_step;

    localparam t_reply R_NONE = '0;
    localparam t_reply R_MISS = '{1'b0, 8'd0, STATUS_NOT_FOUND, 1'b0};
    localparam t_reply R_DONE = '{1'b1, 8'd0, STATUS_DONE, 1'b0};
    localparam logic [KEY_W-1:0] ONES = '1;
    localparam int DIRECTED_N = 25;
    localparam int PHASES = 7;
    localparam int PHASE_ITEMS = 155;
    localparam int QUIET_LIMIT = 2000;

    localparam t_step DIRECTED [DIRECTED_N] = '{
        '{KIND_TICK,       64'd0, 8'd0,   1'b1, '{1'b1, 8'd0, STATUS_DONE, 1'b1}},
        '{KIND_UNREGISTER, 64'd0, 8'd0,   1'b1, R_MISS},
        '{KIND_RELOAD,     64'd0, 8'd0,   1'b1, R_MISS},
        '{KIND_UNREGISTER, 64'd0, 8'd255, 1'b1, R_MISS},
        '{KIND_RELOAD,     ONES,  8'd65,  1'b1, R_MISS},
        '{KIND_RELOAD,     64'd0, 8'd1,   1'b1, R_MISS},
        '{KIND_REGISTER,   64'd0, 8'd0,   1'b1, '{1'b1, 8'd1, STATUS_DONE, 1'b0}},
        '{KIND_REGISTER,   ONES,  8'd255, 1'b1, '{1'b1, 8'd2, STATUS_DONE, 1'b0}},
        '{KIND_REGISTER,   64'd0, 8'd0,   1'b1, '{1'b0, 8'd1, STATUS_DUPLICATE, 1'b0}},
        '{KIND_REGISTER,   ONES,  8'd0,   1'b1, '{1'b0, 8'd2, STATUS_DUPLICATE, 1'b0}},
        '{KIND_RELOAD,     64'd0, 8'd1,   1'b1, R_DONE},
        '{KIND_RELOAD,     64'd0, 8'd2,   1'b1, R_DONE},
        '{KIND_REGISTER,   64'h5A5A_5A5A_5A5A_5A5A, 8'd0, 1'b1,
          '{1'b1, 8'd3, STATUS_DONE, 1'b0}},
        '{KIND_RELOAD,     64'd0, 8'd3,   1'b1, R_DONE},
        '{KIND_TICK,       ONES,  8'd255, 1'b0, R_NONE},
        '{KIND_UNREGISTER, 64'd0, 8'd1,   1'b1, R_DONE},
        '{KIND_UNREGISTER, 64'd0, 8'd1,   1'b1, R_MISS},
        '{KIND_REGISTER,   64'hA5A5_A5A5_A5A5_A5A5, 8'd0, 1'b1,
          '{1'b1, 8'd1, STATUS_DONE, 1'b0}},
        '{KIND_TICK,       64'd0, 8'd0,   1'b0, R_NONE},
        '{KIND_RELOAD,     64'd0, 8'd64,  1'b1, R_MISS},
        '{KIND_REGISTER,   64'd0, 8'd0,   1'b0, R_NONE},
        '{KIND_RELOAD,     64'd0, 8'd4,   1'b0, R_NONE},
        '{KIND_TICK,       64'd0, 8'd0,   1'b0, R_NONE},
        '{KIND_UNREGISTER, 64'd0, 8'd2,   1'b1, R_DONE},
        '{KIND_TICK,       64'd0, 8'd0,   1'b0, R_NONE}
    };

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_start = 1'b0;
    logic [1:0]       i_kind = '0;
    logic [KEY_W-1:0] i_task_key = '0;
    logic [ID_W-1:0]  i_task_id = '0;
    logic             i_cfg_we = 1'b0;
    logic [CNT_W-1:0] i_cfg_wdata = '0;
    logic             o_busy;
    logic             o_valid;
    logic             o_ok;
    logic [ID_W-1:0]  o_result_id;
    logic [1:0]       o_status;
    logic             o_feed;

    logic             held [SLOTS] = '{default: 1'b0};
    logic [KEY_W-1:0] held_key [SLOTS] = '{default: '0};
    logic [CNT_W-1:0] ticks_left [SLOTS] = '{default: '0};
    logic             tripped = 1'b0;
    logic [CNT_W-1:0] reload_val = TIMEOUT_RESET;

    t_reply pending_replies [$];
    int     mismatches = 0;
    int     quiet = 0;
    bit     may_idle = 1'b1;

    task_watchdog_supervisor DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_kind      (i_kind),
        .i_task_key  (i_task_key),
        .i_task_id   (i_task_id),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_ok        (o_ok),
        .o_result_id (o_result_id),
        .o_status    (o_status),
        .o_feed      (o_feed)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_reply supervise(t_kind kind, logic [KEY_W-1:0] key,
                                         logic [ID_W-1:0] id);
        t_reply r;
        int     hit;
        int     vacant;
        bit     stopped;
        r = R_NONE;
        hit = -1;
        vacant = -1;
        stopped = 1'b0;
        case (kind)
            KIND_REGISTER: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (hit < 0 && held[i] && held_key[i] == key) hit = i;
                    if (vacant < 0 && !held[i]) vacant = i;
                end
                if (hit >= 0) begin
                    r.status = STATUS_DUPLICATE;
                    r.rid = ID_W'(hit + 1);
                end else if (vacant < 0) begin
                    r.status = STATUS_FULL;
                end else begin
                    held[vacant] = 1'b1;
                    held_key[vacant] = key;
                    r.ok = 1'b1;
                    r.rid = ID_W'(vacant + 1);
                end
            end
            KIND_UNREGISTER, KIND_RELOAD: begin
                if (id == 0 || id > SLOTS || !held[id - 1]) begin
                    r.status = STATUS_NOT_FOUND;
                end else begin
                    if (kind == KIND_UNREGISTER) held[id - 1] = 1'b0;
                    else ticks_left[id - 1] = reload_val;
                    r.ok = 1'b1;
                end
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!stopped && held[i]) begin
                        if (ticks_left[i] == 0) begin
                            tripped = 1'b1;
                            r.rid = ID_W'(i + 1);
                            stopped = 1'b1;
                        end else begin
                            ticks_left[i] = ticks_left[i] - 1'b1;
                        end
                    end
                end
                r.ok = !tripped;
                r.feed = !tripped;
            end
        endcase
        return r;
    endfunction

    function automatic int first_held(int from);
        for (int n = 0; n < SLOTS; n++) begin
            if (held[(from + n) % SLOTS]) return (from + n) % SLOTS;
        end
        return -1;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        int s;
        r = $urandom_range(99);
        s = first_held($urandom_range(SLOTS - 1));
        if (r < 25 && s >= 0) return held_key[s];
        if (r < 45) return KEY_W'($urandom_range(15));
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        int r;
        int s;
        r = $urandom_range(99);
        s = first_held($urandom_range(SLOTS - 1));
        if (r < 75 && s >= 0) return ID_W'(s + 1);
        if (r < 80) return '0;
        if (r < 88) return ID_W'($urandom_range(255, SLOTS + 1));
        return ID_W'($urandom_range(255));
    endfunction

    task automatic issue(t_kind kind, logic [KEY_W-1:0] key, logic [ID_W-1:0] id,
                         logic typed, t_reply want);
        t_reply predicted;
        while (may_idle && $urandom_range(99) < 15) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_kind <= kind;
        i_task_key <= key;
        i_task_id <= id;
        do @(posedge i_clk); while (o_busy);
        predicted = supervise(kind, key, id);
        pending_replies.push_back(typed ? want : predicted);
    endtask

    task automatic random_request(int reg_pct, int unreg_pct, int reload_pct,
                                  bit allow_trip);
        t_kind            kind;
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
        int               r;
        r = $urandom_range(99);
        if (r < reg_pct) kind = KIND_REGISTER;
        else if (r < reg_pct + unreg_pct) kind = KIND_UNREGISTER;
        else if (r < reg_pct + unreg_pct + reload_pct) kind = KIND_RELOAD;
        else kind = KIND_TICK;
        key = pick_key();
        id = pick_id();
        // Until faults are allowed, an expired slot is reloaded instead of ticked.
        if (kind == KIND_TICK && !allow_trip) begin
            for (int i = SLOTS - 1; i >= 0; i--) begin
                if (held[i] && ticks_left[i] == 0) begin
                    kind = KIND_RELOAD;
                    id = ID_W'(i + 1);
                end
            end
        end
        issue(kind, key, id, 1'b0, R_NONE);
    endtask

    task automatic write_timeout(logic [CNT_W-1:0] v);
        i_start <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        reload_val = v;
    endtask

    task automatic check(string what, logic [7:0] exp, logic [7:0] act);
        if (act !== exp) begin
            $display("%0t: %s expected %0d, actual %0d", $time, what, exp, act);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : collect
        t_reply want;
        if (i_rst_n && o_valid) begin
            if (pending_replies.size() == 0) begin
                $display({"%0t: unexpected result, expected none, ",
                          "actual ok=%0d id=%0d status=%0d feed=%0d"},
                         $time, o_ok, o_result_id, o_status, o_feed);
                mismatches++;
            end else begin
                want = pending_replies.pop_front();
                check("ok", 8'(want.ok), 8'(o_ok));
                check("result_id", want.rid, o_result_id);
                check("status", 8'(want.status), 8'(o_status));
                check("feed", 8'(want.feed), 8'(o_feed));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [CNT_W-1:0] v;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int n = 0; n < DIRECTED_N; n++) begin
            issue(DIRECTED[n].kind, DIRECTED[n].key, DIRECTED[n].id,
                  DIRECTED[n].typed, DIRECTED[n].want);
        end
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: v = 32'd1;
                1: v = 32'hFFFF_FFFF;
                2: v = $urandom_range(40, 2);
                3: v = 32'd2;
                4: begin
                    v = $urandom;
                    if (v == 0) v = 32'd1;
                end
                5: v = $urandom_range(12, 3);
                default: v = $urandom_range(8, 1);
            endcase
            write_timeout(v);
            may_idle = (p != 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1) random_request(75, 5, 10, 1'b0);
                else if (p >= 4) random_request(30, 25, 20, p == PHASES - 1);
                else random_request(35, 15, 25, 1'b0);
            end
        end
        i_start <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (SLOTS + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- task_watchdog_supervisor.f -----
hdl/twd_pkg.sv
hdl/twd_cell.sv
hdl/task_watchdog_supervisor.sv
verif/task_watchdog_supervisor_tb.sv
